>>> rtl/pcdr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the pair collision detect/resolve block.
// No dependencies; every other file of the block imports this package.
package pcdr_pkg;

   localparam int COORD_WIDTH_DEFAULT = 32;

   localparam logic [16:0] RESTITUTION_RESET = 17'd52429;
   localparam logic [16:0] ONE_Q             = 17'd65536;
   localparam logic [16:0] HALF_Q            = 17'd32768;

   // iterative divide / square-root unit geometry
   localparam int DVD_W      = 92;   // dividend: 64-bit speed times 28-bit direction
   localparam int DVS_W      = 58;   // divisor: squared direction length
   localparam int QUO_W      = 41;   // quotient bits produced
   localparam int REM_W      = 59;
   localparam int SQRT_IN_W  = 64;
   localparam int DIV_ITERS  = QUO_W;
   localparam int SQRT_ITERS = SQRT_IN_W / 2;

   // datapath micro-operations
   localparam logic [4:0] OP_NONE   = 5'd0;
   localparam logic [4:0] OP_LOAD_A = 5'd1;
   localparam logic [4:0] OP_LOAD_B = 5'd2;
   localparam logic [4:0] OP_DIFF   = 5'd3;
   localparam logic [4:0] OP_SQ     = 5'd4;
   localparam logic [4:0] OP_RSQ    = 5'd5;
   localparam logic [4:0] OP_HIT    = 5'd6;
   localparam logic [4:0] OP_SHR    = 5'd7;
   localparam logic [4:0] OP_SHL    = 5'd8;
   localparam logic [4:0] OP_DOT    = 5'd9;
   localparam logic [4:0] OP_NSQ    = 5'd10;
   localparam logic [4:0] OP_NEG    = 5'd11;
   localparam logic [4:0] OP_ESQ    = 5'd12;
   localparam logic [4:0] OP_SQRT   = 5'd13;
   localparam logic [4:0] OP_MASS   = 5'd14;
   localparam logic [4:0] OP_WDIV   = 5'd15;
   localparam logic [4:0] OP_W      = 5'd16;
   localparam logic [4:0] OP_FA     = 5'd17;
   localparam logic [4:0] OP_FB     = 5'd18;
   localparam logic [4:0] OP_PLO    = 5'd19;
   localparam logic [4:0] OP_PHI    = 5'd20;
   localparam logic [4:0] OP_QDIV   = 5'd21;
   localparam logic [4:0] OP_DA     = 5'd22;
   localparam logic [4:0] OP_DB     = 5'd23;
   localparam logic [4:0] OP_UPD    = 5'd24;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] axis;
      logic       sel_b;
   } pcdr_cmd_type;

   typedef struct packed {
      logic hit;
      logic mx_zero;
      logic norm_hi;
      logic norm_lo;
      logic s_neg;
      logic st_a;
      logic st_b;
      logic tot_zero;
      logic busy;
   } pcdr_stat_type;

endpackage

>>> rtl/pcdr_iter.sv
`timescale 1ns / 1ps
// Shared iterative unit: restoring division one quotient bit per cycle, or
// integer square root one result bit per cycle. Depends on pcdr_pkg.
module pcdr_iter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           is_sqrt,
   input  logic [pcdr_pkg::DVD_W-1:0]     dividend,
   input  logic [pcdr_pkg::DVS_W-1:0]     divisor,
   output logic                           busy,
   output logic [pcdr_pkg::QUO_W-1:0]     result
);
   import pcdr_pkg::*;

   localparam int CNT_W = $clog2(DIV_ITERS + 1);

   logic             busy_ff, busy_in;
   logic             mode_ff, mode_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [DVD_W-1:0] shf_ff, shf_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [REM_W-1:0] rdiv, rsqt, trial;

   always_comb begin
      rdiv    = {rem_ff[REM_W-2:0], shf_ff[DVD_W-1]};
      rsqt    = {rem_ff[REM_W-3:0], shf_ff[DVD_W-1 -: 2]};
      trial   = REM_W'({quo_ff, 2'b01});
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      shf_in  = shf_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         mode_in = is_sqrt;
         quo_in  = '0;
         dvs_in  = divisor;
         if (is_sqrt) begin
            rem_in = '0;
            shf_in = {dividend[SQRT_IN_W-1:0], (DVD_W-SQRT_IN_W)'(0)};
            cnt_in = CNT_W'(SQRT_ITERS);
         end else begin
            // upper dividend bits are below the divisor whenever the quotient fits
            rem_in = REM_W'(dividend[DVD_W-1:QUO_W]);
            shf_in = dividend << (DVD_W - QUO_W);
            cnt_in = CNT_W'(DIV_ITERS);
         end
      end else if (busy_ff) begin
         if (mode_ff) begin
            if (rsqt >= trial) begin
               rem_in = rsqt - trial;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rsqt;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            shf_in = shf_ff << 2;
         end else begin
            if (rdiv >= REM_W'(dvs_ff)) begin
               rem_in = rdiv - REM_W'(dvs_ff);
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rdiv;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            shf_in = shf_ff << 1;
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      shf_ff  <= shf_in;
      dvs_ff  <= dvs_in;
   end

   assign busy   = busy_ff;
   assign result = quo_ff;

endmodule

>>> rtl/pcdr_dp.sv
`timescale 1ns / 1ps
// Datapath: held object A, object B, overlap test, direction, weights, impulse.
// Depends on pcdr_pkg and pcdr_iter; driven by pcdr_ctrl commands.
module pcdr_dp #(
   parameter int COORD_WIDTH = pcdr_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pcdr_pkg::pcdr_cmd_type  cmd,
   output pcdr_pkg::pcdr_stat_type stat,
   input  logic signed [31:0]      req_pos_x,
   input  logic signed [31:0]      req_pos_y,
   input  logic signed [31:0]      req_pos_z,
   input  logic [30:0]             req_ext_x,
   input  logic [30:0]             req_ext_y,
   input  logic [30:0]             req_ext_z,
   input  logic signed [31:0]      req_vel_x,
   input  logic signed [31:0]      req_vel_y,
   input  logic signed [31:0]      req_vel_z,
   input  logic                    req_is_sphere,
   input  logic                    req_is_static,
   input  logic                    csr_wr_en,
   input  logic [16:0]             csr_wr_data,
   output logic                    rsp_collided,
   output logic signed [31:0]      rsp_new_vel_x,
   output logic signed [31:0]      rsp_new_vel_y,
   output logic signed [31:0]      rsp_new_vel_z
);
   import pcdr_pkg::*;

   localparam int PW = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;
   localparam int SH = 32 - PW;

   function automatic logic [31:0] sat32(input logic signed [45:0] v);
      if (v > 46'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (v < -46'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   logic signed [31:0] pos_a_ff[3], pos_a_in[3], pos_b_ff[3], pos_b_in[3];
   logic signed [31:0] vel_a_ff[3], vel_a_in[3], vel_b_ff[3], vel_b_in[3];
   logic signed [31:0] na_ff[3], na_in[3], nb_ff[3], nb_in[3];
   logic [30:0]        ext_a_ff[3], ext_a_in[3], ext_b_ff[3], ext_b_in[3];
   logic               sph_a_ff, sph_a_in, st_a_ff, st_a_in;
   logic               sph_b_ff, sph_b_in, st_b_ff, st_b_in;
   logic               hit_ff, hit_in;
   logic [32:0]        dmag_ff[3], dmag_in[3], um_ff[3], um_in[3];
   logic [2:0]         dneg_ff, dneg_in;
   logic [66:0]        dist_ff, dist_in;
   logic [63:0]        rsq_ff, rsq_in;
   logic signed [63:0] s_ff, s_in;
   logic [57:0]        n_ff, n_in;
   logic [63:0]        m_ff, m_in, esum_ff, esum_in;
   logic [31:0]        mass_a_ff, mass_a_in, mass_b_ff, mass_b_in;
   logic [16:0]        wa_ff, wa_in, wb_ff, wb_in;
   logic [18:0]        fa_ff, fa_in, fb_ff, fb_in;
   logic [91:0]        prod_ff, prod_in;
   logic [59:0]        ta_ff, ta_in, tb_ff, tb_in;
   logic [16:0]        rest_ff, rest_in;

   logic signed [31:0] req_pos[3], req_vel[3], pos_sx[3];
   logic [30:0]        req_ext[3];
   logic [32:0]        tot;
   logic               box_miss;
   logic               it_start, it_sqrt, it_busy;
   logic [DVD_W-1:0]   it_dvd;
   logic [DVS_W-1:0]   it_dvs;
   logic [QUO_W-1:0]   it_res;

   assign req_pos[0] = req_pos_x;
   assign req_pos[1] = req_pos_y;
   assign req_pos[2] = req_pos_z;
   assign req_vel[0] = req_vel_x;
   assign req_vel[1] = req_vel_y;
   assign req_vel[2] = req_vel_z;
   assign req_ext[0] = req_ext_x;
   assign req_ext[1] = req_ext_y;
   assign req_ext[2] = req_ext_z;

   assign tot = {1'b0, mass_a_ff} + {1'b0, mass_b_ff};

   // keep the low PW bits of each position, sign-extended
   always_comb begin
      logic signed [31:0] t;
      for (int i = 0; i < 3; i++) begin
         t         = req_pos[i] << SH;
         pos_sx[i] = t >>> SH;
      end
   end

   // box test: miss when twice the centre gap on any axis exceeds the summed full sizes (sphere radius doubled)
   always_comb begin
      logic [31:0] ha, hb;
      box_miss = 1'b0;
      for (int i = 0; i < 3; i++) begin
         ha = sph_a_ff ? {ext_a_ff[i], 1'b0} : {1'b0, ext_a_ff[i]};
         hb = sph_b_ff ? {ext_b_ff[i], 1'b0} : {1'b0, ext_b_ff[i]};
         if ({dmag_ff[i], 1'b0} > 34'({1'b0, ha} + {1'b0, hb})) begin
            box_miss = 1'b1;
         end
      end
   end

   always_comb begin
      logic signed [32:0] dpos;
      logic signed [32:0] dv;
      logic signed [28:0] ums;
      logic signed [61:0] dot_p;
      logic [65:0]        sq;
      logic [31:0]        rs;
      logic [55:0]        nsq;
      logic [30:0]        esel;
      logic [61:0]        esq;
      logic [17:0]        onep;
      logic [16:0]        wsel;
      logic [34:0]        fp;
      logic [31:0]        mhalf;
      logic [59:0]        pp;
      logic [18:0]        fsel;
      logic [59:0]        tp;
      logic [43:0]        dlt_a, dlt_b;
      logic signed [45:0] va46, vb46, ua, ub;

      pos_a_in  = pos_a_ff;
      pos_b_in  = pos_b_ff;
      vel_a_in  = vel_a_ff;
      vel_b_in  = vel_b_ff;
      ext_a_in  = ext_a_ff;
      ext_b_in  = ext_b_ff;
      sph_a_in  = sph_a_ff;
      st_a_in   = st_a_ff;
      sph_b_in  = sph_b_ff;
      st_b_in   = st_b_ff;
      na_in     = na_ff;
      nb_in     = nb_ff;
      hit_in    = hit_ff;
      dmag_in   = dmag_ff;
      um_in     = um_ff;
      dneg_in   = dneg_ff;
      dist_in   = dist_ff;
      rsq_in    = rsq_ff;
      s_in      = s_ff;
      n_in      = n_ff;
      m_in      = m_ff;
      esum_in   = esum_ff;
      mass_a_in = mass_a_ff;
      mass_b_in = mass_b_ff;
      wa_in     = wa_ff;
      wb_in     = wb_ff;
      fa_in     = fa_ff;
      fb_in     = fb_ff;
      prod_in   = prod_ff;
      ta_in     = ta_ff;
      tb_in     = tb_ff;
      rest_in   = csr_wr_en ? csr_wr_data : rest_ff;

      dv    = {vel_b_ff[cmd.axis][31], vel_b_ff[cmd.axis]}
              - {vel_a_ff[cmd.axis][31], vel_a_ff[cmd.axis]};
      ums   = {1'b0, um_ff[cmd.axis][27:0]};
      dot_p = dv * ums;
      sq    = dmag_ff[cmd.axis] * dmag_ff[cmd.axis];
      rs    = {1'b0, ext_a_ff[0]} + {1'b0, ext_b_ff[0]};
      nsq   = um_ff[cmd.axis][27:0] * um_ff[cmd.axis][27:0];
      esel  = cmd.sel_b ? ext_b_ff[cmd.axis] : ext_a_ff[cmd.axis];
      esq   = esel * esel;
      onep  = {1'b0, ONE_Q} + {1'b0, rest_ff};
      wsel  = (cmd.op == OP_FB) ? wb_ff : wa_ff;
      fp    = onep * wsel;
      mhalf = (cmd.op == OP_PHI) ? m_ff[63:32] : m_ff[31:0];
      pp    = mhalf * um_ff[cmd.axis][27:0];
      fsel  = (cmd.op == OP_DB) ? fb_ff : fa_ff;
      tp    = it_res * fsel;
      dlt_a = ta_ff[59:16];
      dlt_b = tb_ff[59:16];
      va46  = 46'(vel_a_ff[cmd.axis]);
      vb46  = 46'(vel_b_ff[cmd.axis]);
      ua    = dneg_ff[cmd.axis] ? va46 + $signed({2'b00, dlt_a})
                                : va46 - $signed({2'b00, dlt_a});
      ub    = dneg_ff[cmd.axis] ? vb46 - $signed({2'b00, dlt_b})
                                : vb46 + $signed({2'b00, dlt_b});

      case (cmd.op)
         OP_LOAD_A: begin
            for (int i = 0; i < 3; i++) begin
               pos_a_in[i] = pos_sx[i];
               ext_a_in[i] = req_ext[i];
               vel_a_in[i] = req_vel[i];
            end
            sph_a_in = req_is_sphere;
            st_a_in  = req_is_static;
         end
         OP_LOAD_B: begin
            for (int i = 0; i < 3; i++) begin
               pos_b_in[i] = pos_sx[i];
               ext_b_in[i] = req_ext[i];
               vel_b_in[i] = req_vel[i];
            end
            sph_b_in = req_is_sphere;
            st_b_in  = req_is_static;
         end
         OP_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               dpos       = {pos_b_ff[i][31], pos_b_ff[i]} - {pos_a_ff[i][31], pos_a_ff[i]};
               dneg_in[i] = dpos[32];
               dmag_in[i] = dpos[32] ? 33'(-dpos) : 33'(dpos);
            end
            na_in   = vel_a_ff;
            nb_in   = vel_b_ff;
            dist_in = '0;
            hit_in  = 1'b0;
         end
         OP_SQ: begin
            dist_in = dist_ff + 67'(sq);
         end
         OP_RSQ: begin
            rsq_in = rs * rs;
         end
         OP_HIT: begin
            hit_in = (sph_a_ff && sph_b_ff) ? (dist_ff <= 67'(rsq_ff)) : !box_miss;
            um_in  = dmag_ff;
            s_in   = '0;
            n_in   = '0;
         end
         OP_SHR: begin
            for (int i = 0; i < 3; i++) begin
               um_in[i] = um_ff[i] >> 1;
            end
         end
         OP_SHL: begin
            for (int i = 0; i < 3; i++) begin
               um_in[i] = um_ff[i] << 1;
            end
         end
         OP_DOT: begin
            s_in = dneg_ff[cmd.axis] ? s_ff - 64'(dot_p) : s_ff + 64'(dot_p);
         end
         OP_NSQ: begin
            n_in = n_ff + 58'(nsq);
         end
         OP_NEG: begin
            m_in    = 64'(-s_ff);
            esum_in = '0;
         end
         OP_ESQ: begin
            esum_in = esum_ff + 64'(esq);
         end
         OP_MASS: begin
            if (cmd.sel_b) begin
               mass_b_in = it_res[31:0];
            end else begin
               mass_a_in = it_res[31:0];
            end
            esum_in = '0;
         end
         OP_W: begin
            case ({st_a_ff, st_b_ff})
               2'b11: begin
                  wa_in = '0;
                  wb_in = '0;
               end
               2'b10: begin
                  wa_in = '0;
                  wb_in = ONE_Q;
               end
               2'b01: begin
                  wa_in = ONE_Q;
                  wb_in = '0;
               end
               default: begin
                  wa_in = (tot == '0) ? HALF_Q : it_res[16:0];
                  wb_in = ONE_Q - ((tot == '0) ? HALF_Q : it_res[16:0]);
               end
            endcase
         end
         OP_FA: begin
            fa_in = fp[34:16];
         end
         OP_FB: begin
            fb_in = fp[34:16];
         end
         OP_PLO: begin
            prod_in = 92'(pp);
         end
         OP_PHI: begin
            prod_in = prod_ff + (92'(pp) << 32);
         end
         OP_DA: begin
            ta_in = tp;
         end
         OP_DB: begin
            tb_in = tp;
         end
         OP_UPD: begin
            na_in[cmd.axis] = sat32(ua);
            nb_in[cmd.axis] = sat32(ub);
         end
         default: begin
         end
      endcase
   end

   // feed the shared iterative unit
   always_comb begin
      it_start = 1'b0;
      it_sqrt  = 1'b0;
      it_dvd   = prod_ff;
      it_dvs   = n_ff;
      case (cmd.op)
         OP_SQRT: begin
            it_start = 1'b1;
            it_sqrt  = 1'b1;
            it_dvd   = DVD_W'(esum_ff);
         end
         OP_WDIV: begin
            it_start = 1'b1;
            it_dvd   = DVD_W'({mass_b_ff, 16'h0000});
            it_dvs   = DVS_W'(tot);
         end
         OP_QDIV: begin
            it_start = 1'b1;
         end
         default: begin
         end
      endcase
   end

   pcdr_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .start    (it_start),
      .is_sqrt  (it_sqrt),
      .dividend (it_dvd),
      .divisor  (it_dvs),
      .busy     (it_busy),
      .result   (it_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            pos_a_ff[i] <= '0;
            ext_a_ff[i] <= '0;
            vel_a_ff[i] <= '0;
         end
         sph_a_ff <= 1'b0;
         st_a_ff  <= 1'b0;
         hit_ff   <= 1'b0;
         rest_ff  <= RESTITUTION_RESET;
      end else begin
         pos_a_ff <= pos_a_in;
         ext_a_ff <= ext_a_in;
         vel_a_ff <= vel_a_in;
         sph_a_ff <= sph_a_in;
         st_a_ff  <= st_a_in;
         hit_ff   <= hit_in;
         rest_ff  <= rest_in;
      end
      pos_b_ff  <= pos_b_in;
      ext_b_ff  <= ext_b_in;
      vel_b_ff  <= vel_b_in;
      sph_b_ff  <= sph_b_in;
      st_b_ff   <= st_b_in;
      na_ff     <= na_in;
      nb_ff     <= nb_in;
      dmag_ff   <= dmag_in;
      um_ff     <= um_in;
      dneg_ff   <= dneg_in;
      dist_ff   <= dist_in;
      rsq_ff    <= rsq_in;
      s_ff      <= s_in;
      n_ff      <= n_in;
      m_ff      <= m_in;
      esum_ff   <= esum_in;
      mass_a_ff <= mass_a_in;
      mass_b_ff <= mass_b_in;
      wa_ff     <= wa_in;
      wb_ff     <= wb_in;
      fa_ff     <= fa_in;
      fb_ff     <= fb_in;
      prod_ff   <= prod_in;
      ta_ff     <= ta_in;
      tb_ff     <= tb_in;
   end

   always_comb begin
      stat          = '0;
      stat.hit      = hit_ff;
      stat.mx_zero  = (um_ff[0] == '0) && (um_ff[1] == '0) && (um_ff[2] == '0);
      stat.norm_hi  = |(um_ff[0][32:28] | um_ff[1][32:28] | um_ff[2][32:28]);
      stat.norm_lo  = !(um_ff[0][27] | um_ff[1][27] | um_ff[2][27]);
      stat.s_neg    = s_ff[63];
      stat.st_a     = st_a_ff;
      stat.st_b     = st_b_ff;
      stat.tot_zero = (tot == '0);
      stat.busy     = it_busy;
   end

   assign rsp_collided  = hit_ff;
   assign rsp_new_vel_x = cmd.sel_b ? nb_ff[0] : na_ff[0];
   assign rsp_new_vel_y = cmd.sel_b ? nb_ff[1] : na_ff[1];
   assign rsp_new_vel_z = cmd.sel_b ? nb_ff[2] : na_ff[2];

endmodule

>>> rtl/pcdr_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences datapath micro-operations and both handshakes.
// Depends on pcdr_pkg.
module pcdr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_second,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_object_b,
   output logic                    rsp_last,
   output pcdr_pkg::pcdr_cmd_type  cmd,
   input  pcdr_pkg::pcdr_stat_type stat
);
   import pcdr_pkg::*;

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_DIFF  = 5'd1;
   localparam logic [4:0] S_SQ    = 5'd2;
   localparam logic [4:0] S_RSQ   = 5'd3;
   localparam logic [4:0] S_HIT   = 5'd4;
   localparam logic [4:0] S_CHK   = 5'd5;
   localparam logic [4:0] S_NORM  = 5'd6;
   localparam logic [4:0] S_DOT   = 5'd7;
   localparam logic [4:0] S_NSQ   = 5'd8;
   localparam logic [4:0] S_SCHK  = 5'd9;
   localparam logic [4:0] S_ESQ   = 5'd10;
   localparam logic [4:0] S_SQRT  = 5'd11;
   localparam logic [4:0] S_SWAIT = 5'd12;
   localparam logic [4:0] S_WDIV  = 5'd13;
   localparam logic [4:0] S_WWAIT = 5'd14;
   localparam logic [4:0] S_W     = 5'd15;
   localparam logic [4:0] S_FA    = 5'd16;
   localparam logic [4:0] S_FB    = 5'd17;
   localparam logic [4:0] S_PLO   = 5'd18;
   localparam logic [4:0] S_PHI   = 5'd19;
   localparam logic [4:0] S_QDIV  = 5'd20;
   localparam logic [4:0] S_QWAIT = 5'd21;
   localparam logic [4:0] S_DA    = 5'd22;
   localparam logic [4:0] S_DB    = 5'd23;
   localparam logic [4:0] S_UPD   = 5'd24;
   localparam logic [4:0] S_OUTA  = 5'd25;
   localparam logic [4:0] S_OUTB  = 5'd26;

   logic [4:0] state_ff, state_in;
   logic [1:0] ax_ff, ax_in;
   logic       sel_ff, sel_in;

   always_comb begin
      state_in  = state_ff;
      ax_in     = ax_ff;
      sel_in    = sel_ff;
      cmd.op    = OP_NONE;
      cmd.axis  = ax_ff;
      cmd.sel_b = sel_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_second) begin
                  cmd.op   = OP_LOAD_B;
                  state_in = S_DIFF;
               end else begin
                  cmd.op = OP_LOAD_A;
               end
            end
         end
         S_DIFF: begin
            cmd.op   = OP_DIFF;
            ax_in    = 2'd0;
            state_in = S_SQ;
         end
         S_SQ: begin
            cmd.op = OP_SQ;
            ax_in  = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               state_in = S_RSQ;
            end
         end
         S_RSQ: begin
            cmd.op   = OP_RSQ;
            state_in = S_HIT;
         end
         S_HIT: begin
            cmd.op   = OP_HIT;
            state_in = S_CHK;
         end
         S_CHK: begin
            // coincident centres report the hit but change nothing
            if (!stat.hit || stat.mx_zero) begin
               state_in = S_OUTA;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (stat.norm_hi) begin
               cmd.op = OP_SHR;
            end else if (stat.norm_lo) begin
               cmd.op = OP_SHL;
            end else begin
               ax_in    = 2'd0;
               state_in = S_DOT;
            end
         end
         S_DOT: begin
            cmd.op   = OP_DOT;
            state_in = S_NSQ;
         end
         S_NSQ: begin
            cmd.op = OP_NSQ;
            ax_in  = ax_ff + 2'd1;
            state_in = (ax_ff == 2'd2) ? S_SCHK : S_DOT;
         end
         S_SCHK: begin
            if (!stat.s_neg) begin
               state_in = S_OUTA;
            end else begin
               cmd.op = OP_NEG;
               ax_in  = 2'd0;
               sel_in = 1'b0;
               state_in = (stat.st_a || stat.st_b) ? S_W : S_ESQ;
            end
         end
         S_ESQ: begin
            cmd.op = OP_ESQ;
            ax_in  = ax_ff + 2'd1;
            if (ax_ff == 2'd2) begin
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            cmd.op   = OP_SQRT;
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            if (!stat.busy) begin
               cmd.op = OP_MASS;
               ax_in  = 2'd0;
               if (sel_ff) begin
                  sel_in   = 1'b0;
                  state_in = S_WDIV;
               end else begin
                  sel_in   = 1'b1;
                  state_in = S_ESQ;
               end
            end
         end
         S_WDIV: begin
            if (stat.tot_zero) begin
               state_in = S_W;
            end else begin
               cmd.op   = OP_WDIV;
               state_in = S_WWAIT;
            end
         end
         S_WWAIT: begin
            if (!stat.busy) begin
               state_in = S_W;
            end
         end
         S_W: begin
            cmd.op   = OP_W;
            state_in = S_FA;
         end
         S_FA: begin
            cmd.op   = OP_FA;
            state_in = S_FB;
         end
         S_FB: begin
            cmd.op   = OP_FB;
            ax_in    = 2'd0;
            state_in = S_PLO;
         end
         S_PLO: begin
            cmd.op   = OP_PLO;
            state_in = S_PHI;
         end
         S_PHI: begin
            cmd.op   = OP_PHI;
            state_in = S_QDIV;
         end
         S_QDIV: begin
            cmd.op   = OP_QDIV;
            state_in = S_QWAIT;
         end
         S_QWAIT: begin
            if (!stat.busy) begin
               state_in = S_DA;
            end
         end
         S_DA: begin
            cmd.op   = OP_DA;
            state_in = S_DB;
         end
         S_DB: begin
            cmd.op   = OP_DB;
            state_in = S_UPD;
         end
         S_UPD: begin
            cmd.op = OP_UPD;
            ax_in  = ax_ff + 2'd1;
            state_in = (ax_ff == 2'd2) ? S_OUTA : S_PLO;
         end
         S_OUTA: begin
            cmd.sel_b = 1'b0;
            if (!rsp_stall) begin
               state_in = S_OUTB;
            end
         end
         S_OUTB: begin
            cmd.sel_b = 1'b1;
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff    <= 2'd0;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff    <= ax_in;
         sel_ff   <= sel_in;
      end
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = (state_ff == S_OUTA) || (state_ff == S_OUTB);
   assign rsp_is_object_b = (state_ff == S_OUTB);
   assign rsp_last        = (state_ff == S_OUTB);

   a_b_follows_a : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_is_object_b) |=> (rsp_valid && rsp_is_object_b))
      else $error("object B result did not follow object A result");

   a_no_req_while_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while results pending");

   a_iter_not_busy : assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_SQRT || cmd.op == OP_WDIV || cmd.op == OP_QDIV) |-> !stat.busy)
      else $error("iterative unit restarted while busy");

   a_load_on_accept : assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD_A || cmd.op == OP_LOAD_B) |-> (req_valid && !req_stall))
      else $error("object load without an accepted transaction");

endmodule

>>> rtl/pair_collision_detect_resolve_top.sv
`timescale 1ns / 1ps
// Top level of the pair collision detect/resolve block.
// Depends on pcdr_pkg, pcdr_ctrl, pcdr_dp (and pcdr_iter below it).

// Objects arrive one transaction at a time on the req_ channel. A transaction
// with req_second low is stored as object A and produces nothing. A transaction
// with req_second high is object B: it is tested against the held A (sphere
// pair by centre distance, anything else as axis-aligned boxes) and produces
// two rsp_ transactions, A's velocity and then B's with rsp_last set. Only one
// object is in work at a time; req_stall stays high from the cycle after a B is
// taken until its second result is taken. A pair that misses, or whose centres
// coincide, passes the difference, squared distance, radius square, hit test
// and check steps before presenting its first result. A hit that recedes adds
// the direction normalization (one bit shift per cycle) and a dot product. An
// approaching hit adds the impulse: two integer square roots for the masses and
// one weight division when neither object is static, then per axis one
// division. All square roots and divisions share one iterative unit producing
// one result bit per cycle. Restitution is written through
// csr_wr_en/csr_wr_data; the user must write it only while the block is idle,
// and the block itself does not enforce this. Reset sets it to 0.8 and clears
// the held object A to zeros. Velocities are Q16.16 and saturate.
module pair_collision_detect_resolve_top #(
   parameter int COORD_WIDTH = pcdr_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // input channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [30:0]        req_ext_x,
   input  logic [30:0]        req_ext_y,
   input  logic [30:0]        req_ext_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic               req_is_sphere,
   input  logic               req_is_static,
   input  logic               req_second,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_is_object_b,
   output logic               rsp_collided,
   output logic signed [31:0] rsp_new_vel_x,
   output logic signed [31:0] rsp_new_vel_y,
   output logic signed [31:0] rsp_new_vel_z,
   output logic               rsp_last,
   // restitution register
   input  logic               csr_wr_en,
   input  logic [16:0]        csr_wr_data
);
   import pcdr_pkg::*;

   pcdr_cmd_type  cmd;
   pcdr_stat_type stat;

   // sequence the micro-operations and own both handshakes
   pcdr_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_second      (req_second),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_is_object_b (rsp_is_object_b),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .stat            (stat)
   );

   // hold object A, compute the test and the impulse, hold the results
   pcdr_dp #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .req_ext_x     (req_ext_x),
      .req_ext_y     (req_ext_y),
      .req_ext_z     (req_ext_z),
      .req_vel_x     (req_vel_x),
      .req_vel_y     (req_vel_y),
      .req_vel_z     (req_vel_z),
      .req_is_sphere (req_is_sphere),
      .req_is_static (req_is_static),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rsp_collided  (rsp_collided),
      .rsp_new_vel_x (rsp_new_vel_x),
      .rsp_new_vel_y (rsp_new_vel_y),
      .rsp_new_vel_z (rsp_new_vel_z)
   );

endmodule
